// ===== design/tgrr_pkg.sv =====
`default_nettype none

package tgrr_pkg;

  // Slots per group
  localparam int unsigned TEAM_SIZE_DEF = 5;

  // Fixed field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned SID_W  = 4;
  localparam int unsigned RSL_W  = 4;
  localparam int unsigned BASE_W = 8;
  localparam int unsigned SEL_W  = 11;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_NEXT      = 3'd0,
    CMD_CREATE    = 3'd1,
    CMD_KILL_SLOT = 3'd2,
    CMD_KILL_RUN  = 3'd3,
    CMD_KILL_ALL  = 3'd4
  } cmd_t;

  // Incoming request
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             group;
    logic [SID_W-1:0] slot_id;
  } in_req_t;

  // Outgoing result
  typedef struct packed {
    logic [RSL_W-1:0] result_slot;
    logic             found;
    logic [SEL_W-1:0] selector;
  } out_rsp_t;

endpackage

`default_nettype wire

// ===== design/tgrr_rr_pick.sv =====
`default_nettype none

// Round-robin pick within one group: first alive slot after last, wrapping.
module tgrr_rr_pick #(
  parameter int unsigned N = tgrr_pkg::TEAM_SIZE_DEF,
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1
) (
  input  wire logic [N-1:0]  alive,
  input  wire logic [IW-1:0] last,
  output logic      [IW-1:0] pick,
  output logic               any
);

  logic [N-1:0]  upper;
  logic [IW-1:0] idx_hi;
  logic [IW-1:0] idx_all;

  // Keep alive slots above the last one run
  always_comb begin
    for (int i = 0; i < N; i++) begin
      upper[i] = alive[i] && (IW'(i) > last);
    end
  end

  // Lowest set bit of the upper part and of the whole bitmap
  always_comb begin
    idx_hi  = '0;
    idx_all = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (upper[i]) begin
        idx_hi = IW'(i);
      end
      if (alive[i]) begin
        idx_all = IW'(i);
      end
    end
  end

  // Wrap to the bottom when nothing is alive above last
  assign pick = (|upper) ? idx_hi : idx_all;
  assign any  = |alive;

endmodule

`default_nettype wire

// ===== design/two_group_round_robin_task_scheduler.sv =====
// A request is captured in the input register, then executed from there into
// the result register that drives out_data; a stalled result keeps it waiting.
// Throughput: one request per cycle while the result is not stalled; the alive
// bitmaps, last-run slots and running slot update as the result register loads.
// Reset (rst_n low, synchronous): all slots dead, running slot is the last
// second-group slot, both last-run indexes are the last slot, base index 0.
`default_nettype none

module two_group_round_robin_task_scheduler #(
  parameter int unsigned TEAM_SIZE = tgrr_pkg::TEAM_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tgrr_pkg::in_req_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tgrr_pkg::out_rsp_t                 out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tgrr_pkg::BASE_W-1:0]   cfg_wr_data
);

  localparam int unsigned IW     = (TEAM_SIZE > 1) ? $clog2(TEAM_SIZE) : 1;
  localparam int unsigned SLOT_W = $clog2(2 * TEAM_SIZE);
  localparam int unsigned RS_W   = $clog2(2 * TEAM_SIZE + 1);
  localparam logic [RS_W-1:0] NONE_SLOT = RS_W'(2 * TEAM_SIZE);
  localparam logic [RS_W-1:0] TEAM_RS   = RS_W'(TEAM_SIZE);

  // Pipeline control
  logic              in_valid_r;
  tgrr_pkg::in_req_t in_req_r;
  logic              out_valid_r;
  tgrr_pkg::out_rsp_t out_rsp_r;
  logic              advance;
  logic              exec;

  // Scheduler state
  logic [tgrr_pkg::BASE_W-1:0] base_r;
  logic [TEAM_SIZE-1:0]        alive_a_r, alive_a_nxt;
  logic [TEAM_SIZE-1:0]        alive_b_r, alive_b_nxt;
  logic [SLOT_W-1:0]           running_r, running_nxt;
  logic [IW-1:0]               last_a_r, last_a_nxt;
  logic [IW-1:0]               last_b_r, last_b_nxt;

  // Datapath
  logic [IW-1:0]        pick_a, pick_b;
  logic                 any_a, any_b;
  logic [TEAM_SIZE-1:0] kill_sid_a, kill_sid_b, kill_run_a, kill_run_b;
  logic [TEAM_SIZE-1:0] grp_alive;
  logic [IW-1:0]        free_idx;
  logic                 free_any;
  logic [RS_W-1:0]      rslot;
  logic                 found;
  logic                 sel_en;
  logic [tgrr_pkg::BASE_W-1:0] sel_sum;
  tgrr_pkg::out_rsp_t   rsp;

  // Advance when the result register is empty or being taken
  assign advance   = !out_valid_r || !out_stall;
  assign exec      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_rsp_r;

  // Round-robin pickers, one per group
  tgrr_rr_pick #(.N(TEAM_SIZE)) u_pick_a (
    .alive (alive_a_r),
    .last  (last_a_r),
    .pick  (pick_a),
    .any   (any_a)
  );

  tgrr_rr_pick #(.N(TEAM_SIZE)) u_pick_b (
    .alive (alive_b_r),
    .last  (last_b_r),
    .pick  (pick_b),
    .any   (any_b)
  );

  // Decode kill targets as one-hot masks per group
  always_comb begin
    for (int i = 0; i < TEAM_SIZE; i++) begin
      kill_sid_a[i] = (32'(in_req_r.slot_id) == i);
      kill_sid_b[i] = (32'(in_req_r.slot_id) == i + TEAM_SIZE);
      kill_run_a[i] = (32'(running_r) == i);
      kill_run_b[i] = (32'(running_r) == i + TEAM_SIZE);
    end
  end

  // Find the lowest free slot of the requested group
  always_comb begin
    grp_alive = in_req_r.group ? alive_b_r : alive_a_r;
    free_idx  = '0;
    for (int i = TEAM_SIZE - 1; i >= 0; i--) begin
      if (!grp_alive[i]) begin
        free_idx = IW'(i);
      end
    end
    free_any = !(&grp_alive);
  end

  // Execute the command held in the input register
  always_comb begin
    logic pick_first;
    alive_a_nxt = alive_a_r;
    alive_b_nxt = alive_b_r;
    running_nxt = running_r;
    last_a_nxt  = last_a_r;
    last_b_nxt  = last_b_r;
    rslot       = '0;
    found       = 1'b0;
    sel_en      = 1'b0;
    pick_first  = 1'b0;
    case (in_req_r.command)
      tgrr_pkg::CMD_NEXT: begin
        if (!any_a && !any_b) begin
          rslot = NONE_SLOT;
        end else begin
          if (32'(running_r) < TEAM_SIZE) begin
            pick_first = !any_b;
          end else begin
            pick_first = any_a;
          end
          if (pick_first) begin
            last_a_nxt = pick_a;
            rslot      = RS_W'(pick_a);
          end else begin
            last_b_nxt = pick_b;
            rslot      = RS_W'(pick_b) + TEAM_RS;
          end
          running_nxt = SLOT_W'(rslot);
          found       = 1'b1;
          sel_en      = 1'b1;
        end
      end
      tgrr_pkg::CMD_CREATE: begin
        if (free_any) begin
          if (in_req_r.group) begin
            alive_b_nxt[free_idx] = 1'b1;
            rslot = RS_W'(free_idx) + TEAM_RS;
          end else begin
            alive_a_nxt[free_idx] = 1'b1;
            rslot = RS_W'(free_idx);
          end
          found = 1'b1;
        end else begin
          rslot = NONE_SLOT;
        end
      end
      tgrr_pkg::CMD_KILL_SLOT: begin
        alive_a_nxt = alive_a_r & ~kill_sid_a;
        alive_b_nxt = alive_b_r & ~kill_sid_b;
      end
      tgrr_pkg::CMD_KILL_RUN: begin
        alive_a_nxt = alive_a_r & ~kill_run_a;
        alive_b_nxt = alive_b_r & ~kill_run_b;
      end
      tgrr_pkg::CMD_KILL_ALL: begin
        alive_a_nxt = '0;
        alive_b_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Build the result: selector is the wrapped descriptor index times eight
  always_comb begin
    sel_sum         = base_r + tgrr_pkg::BASE_W'(rslot);
    rsp.result_slot = tgrr_pkg::RSL_W'(rslot);
    rsp.found       = found;
    rsp.selector    = sel_en ? {sel_sum, 3'b000} : '0;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      alive_a_r   <= '0;
      alive_b_r   <= '0;
      running_r   <= SLOT_W'(2 * TEAM_SIZE - 1);
      last_a_r    <= IW'(TEAM_SIZE - 1);
      last_b_r    <= IW'(TEAM_SIZE - 1);
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
        alive_a_r   <= alive_a_nxt;
        alive_b_r   <= alive_b_nxt;
        running_r   <= running_nxt;
        last_a_r    <= last_a_nxt;
        last_b_r    <= last_b_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req_r <= in_data;
    end
    if (exec) begin
      out_rsp_r <= rsp;
    end
  end

  // Running slot always names a real slot
  a_running_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(running_r) < 2 * TEAM_SIZE)
    else $error("running slot out of range");

  // A successful pick or create never reports the none slot
  a_found_slot: assert property (@(posedge clk) disable iff (!rst_n)
    found |-> (rslot < NONE_SLOT))
    else $error("found with none slot");

  // Hold scheduler state while a pending request waits on a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && out_stall) |=>
      ($stable(alive_a_r) && $stable(alive_b_r) && $stable(running_r)))
    else $error("state changed under stall");

  // Kill all leaves every slot dead
  a_kill_all: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (in_req_r.command == tgrr_pkg::CMD_KILL_ALL)) |=>
      ((alive_a_r == '0) && (alive_b_r == '0)))
    else $error("kill all left a live slot");

endmodule

`default_nettype wire

// ===== bench/two_group_round_robin_task_scheduler_test.sv =====
module two_group_round_robin_task_scheduler_test;

  localparam int TS = tgrr_pkg::TEAM_SIZE_DEF;
  localparam logic [tgrr_pkg::RSL_W-1:0] NO_SLOT = tgrr_pkg::RSL_W'(2 * TS);
  localparam logic [tgrr_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [tgrr_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int LONG_HOLD = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int TIMEOUT_UNITS = 400000;

  typedef struct {
    tgrr_pkg::in_req_t  req;
    bit                 typed;
    tgrr_pkg::out_rsp_t rsp;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tgrr_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tgrr_pkg::out_rsp_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [tgrr_pkg::BASE_W-1:0] cfg_wr_data = '0;

  // Scheduler state as the bench sees it
  logic [tgrr_pkg::BASE_W-1:0] base_now;
  logic [TS-1:0] alive_lo;
  logic [TS-1:0] alive_hi;
  logic [tgrr_pkg::RSL_W-1:0] running_now;
  logic [2:0] last_lo;
  logic [2:0] last_hi;

  tgrr_pkg::out_rsp_t due_replies[$];
  step_row_t offered_rows[$];
  step_row_t directed_rows[$];

  int fail_count = 0;
  bit send_gaps = 1'b0;
  bit recv_gaps = 1'b0;
  bit hold_asked = 1'b0;
  int hold_left = 0;

  two_group_round_robin_task_scheduler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  initial begin
    #(TIMEOUT_UNITS);
    $display("status: fail");
    $finish;
  end

  task automatic flag_mismatch(string what);
    fail_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // Clear one slot; ignore slot numbers past the second group
  function automatic void drop_slot(logic [tgrr_pkg::SID_W-1:0] s);
    if (s < TS) alive_lo[s] = 1'b0;
    else if (s < 2 * TS) alive_hi[s - TS] = 1'b0;
  endfunction

  // Advance the scheduler state by one request and return its reply
  function automatic tgrr_pkg::out_rsp_t apply_command(tgrr_pkg::in_req_t req);
    tgrr_pkg::out_rsp_t rsp;
    logic [TS-1:0] pool;
    logic [tgrr_pkg::BASE_W-1:0] sum8;
    bit from_first;
    int pos;
    int k;
    rsp = '0;
    case (req.command)
      tgrr_pkg::CMD_NEXT: begin
        if (alive_lo == '0 && alive_hi == '0) begin
          rsp.result_slot = NO_SLOT;
        end else begin
          // alternate groups, fall back to the running group when the other is empty
          if (running_now < TS) from_first = (alive_hi == '0);
          else from_first = (alive_lo != '0);
          pool = from_first ? alive_lo : alive_hi;
          pos = from_first ? int'(last_lo) : int'(last_hi);
          for (k = 0; k < TS; k++) begin
            pos = (pos + 1) % TS;
            if (pool[pos]) break;
          end
          if (from_first) begin
            last_lo = 3'(pos);
            rsp.result_slot = tgrr_pkg::RSL_W'(pos);
          end else begin
            last_hi = 3'(pos);
            rsp.result_slot = tgrr_pkg::RSL_W'(pos + TS);
          end
          running_now = rsp.result_slot;
          rsp.found = 1'b1;
          sum8 = base_now + tgrr_pkg::BASE_W'(rsp.result_slot);
          rsp.selector = {sum8, 3'b000};
        end
      end
      tgrr_pkg::CMD_CREATE: begin
        pool = req.group ? alive_hi : alive_lo;
        rsp.result_slot = NO_SLOT;
        for (k = 0; k < TS; k++) begin
          if (!pool[k]) begin
            pool[k] = 1'b1;
            rsp.result_slot = tgrr_pkg::RSL_W'(k + (req.group ? TS : 0));
            rsp.found = 1'b1;
            break;
          end
        end
        if (req.group) alive_hi = pool;
        else alive_lo = pool;
      end
      tgrr_pkg::CMD_KILL_SLOT: drop_slot(req.slot_id);
      tgrr_pkg::CMD_KILL_RUN: drop_slot(running_now);
      tgrr_pkg::CMD_KILL_ALL: begin
        alive_lo = '0;
        alive_hi = '0;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Track config writes, accepted requests and returned replies
  always @(posedge clk) begin : monitor
    tgrr_pkg::out_rsp_t pred;
    tgrr_pkg::out_rsp_t want;
    step_row_t row;
    if (!rst_n) begin
      base_now = '0;
      alive_lo = '0;
      alive_hi = '0;
      running_now = tgrr_pkg::RSL_W'(2 * TS - 1);
      last_lo = 3'(TS - 1);
      last_hi = 3'(TS - 1);
    end else begin
      if (cfg_wr_en) base_now = cfg_wr_data;
      if (in_valid && !in_stall) begin
        pred = apply_command(in_data);
        if (offered_rows.size() != 0) begin
          row = offered_rows.pop_front();
          due_replies.push_back(row.typed ? row.rsp : pred);
        end else begin
          due_replies.push_back(pred);
        end
      end
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          flag_mismatch("reply with no request waiting");
        end else begin
          want = due_replies.pop_front();
          if (out_data.result_slot !== want.result_slot)
            flag_mismatch($sformatf("result_slot %0d, want %0d",
                                    out_data.result_slot, want.result_slot));
          if (out_data.found !== want.found)
            flag_mismatch($sformatf("found %0d, want %0d", out_data.found, want.found));
          if (out_data.selector !== want.selector)
            flag_mismatch($sformatf("selector %0d, want %0d",
                                    out_data.selector, want.selector));
        end
      end
    end
  end

  // Stall replies at random, or hold off for a long stretch on request
  always @(posedge clk) begin : receiver
    if (hold_asked && hold_left == 0) begin
      hold_left = LONG_HOLD;
      hold_asked = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= recv_gaps && ($urandom_range(99) < 16);
    end
  end

  function automatic step_row_t mk_row(logic [tgrr_pkg::CMD_W-1:0] cmd, logic grp,
                                       logic [tgrr_pkg::SID_W-1:0] sid, bit typed,
                                       logic [tgrr_pkg::RSL_W-1:0] slot, logic fnd);
    step_row_t row;
    row.req = '{command: cmd, group: grp, slot_id: sid};
    row.typed = typed;
    row.rsp = '{result_slot: slot, found: fnd, selector: '0};
    return row;
  endfunction

  // Weighted mix: mostly next and create, with kills keeping slots turning over
  function automatic tgrr_pkg::in_req_t random_request();
    tgrr_pkg::in_req_t req;
    int pick;
    pick = $urandom_range(99);
    if (pick < 42) req.command = tgrr_pkg::CMD_NEXT;
    else if (pick < 69) req.command = tgrr_pkg::CMD_CREATE;
    else if (pick < 84) req.command = tgrr_pkg::CMD_KILL_SLOT;
    else if (pick < 94) req.command = tgrr_pkg::CMD_KILL_RUN;
    else if (pick < 96) req.command = tgrr_pkg::CMD_KILL_ALL;
    else req.command = CMD_SPARE_LO +
                       tgrr_pkg::CMD_W'($urandom_range(CMD_SPARE_HI - CMD_SPARE_LO));
    req.group = 1'($urandom_range(1));
    if ($urandom_range(99) < 80) req.slot_id = tgrr_pkg::SID_W'($urandom_range(2 * TS - 1));
    else req.slot_id = tgrr_pkg::SID_W'($urandom_range(15, 2 * TS));
    return req;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(step_row_t row);
    while (send_gaps && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    offered_rows.push_back(row);
    in_valid <= 1'b1;
    in_data <= row.req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait for every outstanding reply
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(logic [tgrr_pkg::BASE_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [tgrr_pkg::BASE_W-1:0] next_base;
    tgrr_pkg::in_req_t rnd_req;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests; base at its top value so selectors wrap
    write_base(8'd255);
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_NEXT, 1'b0, 4'd0, 1, NO_SLOT, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_KILL_RUN, 1'b0, 4'd0, 1, 4'd0, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b0, 4'd0, 1, 4'd0, 1'b1));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b1, 4'd0, 1, 4'd5, 1'b1));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_NEXT, 1'b1, 4'd15, 0, 4'd0, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b0, 4'd9, 1, 4'd1, 1'b1));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b0, 4'd0, 1, 4'd2, 1'b1));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b0, 4'd0, 1, 4'd3, 1'b1));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b0, 4'd0, 1, 4'd4, 1'b1));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b0, 4'd0, 1, NO_SLOT, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b1, 4'd0, 1, 4'd6, 1'b1));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b1, 4'd0, 1, 4'd7, 1'b1));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b1, 4'd0, 1, 4'd8, 1'b1));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b1, 4'd0, 1, 4'd9, 1'b1));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_CREATE, 1'b1, 4'd15, 1, NO_SLOT, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_NEXT, 1'b0, 4'd0, 0, 4'd0, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_NEXT, 1'b1, 4'd15, 0, 4'd0, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_KILL_SLOT, 1'b1, 4'd15, 1, 4'd0, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_KILL_SLOT, 1'b0, 4'd10, 1, 4'd0, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_KILL_SLOT, 1'b0, 4'd0, 1, 4'd0, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_KILL_RUN, 1'b1, 4'd9, 1, 4'd0, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_NEXT, 1'b0, 4'd0, 0, 4'd0, 1'b0));
    directed_rows.push_back(mk_row(CMD_SPARE_HI, 1'b1, 4'd15, 1, 4'd0, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_KILL_ALL, 1'b1, 4'd15, 1, 4'd0, 1'b0));
    directed_rows.push_back(mk_row(tgrr_pkg::CMD_NEXT, 1'b0, 4'd0, 1, NO_SLOT, 1'b0));
    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Random phases, each with its own base index
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: next_base = 8'd0;
        1: next_base = 8'd1;
        2: next_base = 8'd254;
        4: next_base = 8'd128;
        6: next_base = 8'd255;
        default: next_base = tgrr_pkg::BASE_W'($urandom_range(255));
      endcase
      write_base(next_base);
      // first phase runs back to back with no idling on either side
      send_gaps = (ph != 0);
      recv_gaps = (ph != 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold replies off while requests keep coming, to fill the block
        if (ph == 2 && n == 20) begin
          hold_asked = 1'b1;
          send_gaps = 1'b0;
        end
        if (ph == 2 && n == 90) send_gaps = 1'b1;
        if (ph == 4 && n == ITEMS_PER_PHASE / 2) wait_drained();
        rnd_req = random_request();
        send_request(mk_row(rnd_req.command, rnd_req.group, rnd_req.slot_id,
                            0, 4'd0, 1'b0));
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tgrr_pkg.sv
design/tgrr_rr_pick.sv
design/two_group_round_robin_task_scheduler.sv
bench/two_group_round_robin_task_scheduler_test.sv
